// ===== rtl/bas_pkg.sv =====
`timescale 1ns / 1ps

package bas_pkg;

    // Control that the sequencer broadcasts to every cell of the chain.
    typedef struct packed {
        logic load;   // insert the broadcast value into the sorted row
        logic shift;  // move every value one cell towards the head
    } t_cell_ctrl;

endpackage

// ===== rtl/block_ascending_sorter_top.sv =====
`timescale 1ns / 1ps
// The block's results start in the cycle after its last item is taken,
// and then leave at one item per cycle while the output side is ready.
// It takes no new item while it drains a block, set by the single insertion
// chain being either filled or drained. Synchronous active-low reset empties
// the chain and discards any partial block; no clearing pass is needed.

module block_ascending_sorter_top #(
    parameter int BLOCK_SIZE = 32,
    parameter int DATA_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // s_axis: tdata = value [DATA_WIDTH-1:0], zero padding above
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // m_axis: tdata = sorted_value [DATA_WIDTH-1:0], zero padding above
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import bas_pkg::*;

    localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CNT_WIDTH   = $clog2(BLOCK_SIZE + 1);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                         r_state;
    logic                         n_state;
    logic [CNT_WIDTH-1:0]         r_count;
    logic [CNT_WIDTH-1:0]         n_count;
    logic                         in_acc;
    logic                         out_acc;
    logic                         out_last;
    logic signed [DATA_WIDTH-1:0] new_value;
    t_cell_ctrl                   ctrl;

    logic signed [DATA_WIDTH-1:0] cell_value [BLOCK_SIZE];
    logic                         cell_valid [BLOCK_SIZE];
    logic                         cell_gt    [BLOCK_SIZE];

    assign new_value     = $signed(s_axis_tdata[DATA_WIDTH-1:0]);
    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = (r_state == ST_DRAIN);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign out_last      = (r_count == CNT_WIDTH'(1));

    assign ctrl.load  = in_acc;
    assign ctrl.shift = out_acc;

    // Row of insertion cells; the head cell holds the smallest value.
    for (genvar g = 0; g < BLOCK_SIZE; g++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_value;
        logic                         left_valid;
        logic                         left_gt;
        logic signed [DATA_WIDTH-1:0] right_value;
        logic                         right_valid;

        if (g == 0) begin : g_head
            assign left_value = '0;
            assign left_valid = 1'b1;
            assign left_gt    = 1'b0;
        end else begin : g_mid
            assign left_value = cell_value[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_gt    = cell_gt[g-1];
        end

        if (g == BLOCK_SIZE - 1) begin : g_tail
            assign right_value = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_value = cell_value[g+1];
            assign right_valid = cell_valid[g+1];
        end

        bas_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_new_value  (new_value),
            .i_left_value (left_value),
            .i_left_valid (left_valid),
            .i_left_gt    (left_gt),
            .i_right_value(right_value),
            .i_right_valid(right_valid),
            .o_value      (cell_value[g]),
            .o_valid      (cell_valid[g]),
            .o_gt         (cell_gt[g])
        );
    end

    // Sequencer: count items in while loading, count results out while draining.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    n_count = r_count + CNT_WIDTH'(1);
                    if (r_count == CNT_WIDTH'(BLOCK_SIZE - 1)) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_acc) begin
                    n_count = r_count - CNT_WIDTH'(1);
                    if (out_last) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // The head cell is the output register.
    assign m_axis_tdata = TDATA_WIDTH'($unsigned(cell_value[0]));
    assign m_axis_tlast = out_last;

    // The final result of a block hands control back to loading.
    a_last_reloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && m_axis_tlast) |=> s_axis_tready)
        else $error("sorter did not return to loading after the final item");

    // The item that completes a block starts the drain at once.
    a_full_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_count == CNT_WIDTH'(BLOCK_SIZE - 1))) |=> m_axis_tvalid)
        else $error("full block did not start draining");

    // Results of one block leave in ascending order.
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !m_axis_tlast) |=>
        ($signed($past(cell_value[0])) <= $signed(cell_value[0])))
        else $error("results left out of ascending order");

    // While draining, the head cell always holds a value.
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> cell_valid[0])
        else $error("drain showed an empty head cell");

endmodule

// ===== rtl/bas_cell.sv =====
`timescale 1ns / 1ps

module bas_cell #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bas_pkg::t_cell_ctrl          i_ctrl,
    input  logic signed [DATA_WIDTH-1:0] i_new_value,
    input  logic signed [DATA_WIDTH-1:0] i_left_value,
    input  logic                         i_left_valid,
    input  logic                         i_left_gt,
    input  logic signed [DATA_WIDTH-1:0] i_right_value,
    input  logic                         i_right_valid,
    output logic signed [DATA_WIDTH-1:0] o_value,
    output logic                         o_valid,
    output logic                         o_gt
);
    import bas_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_value;
    logic signed [DATA_WIDTH-1:0] n_value;
    logic                         r_valid;
    logic                         n_valid;
    logic                         take;

    // This cell holds a value larger than the one being inserted.
    assign o_gt = r_valid && (r_value > i_new_value);

    // A cell takes part in an insertion when its value must move right, or
    // when it is the first empty cell of the row.
    assign take = o_gt || (!r_valid && i_left_valid);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctrl.load && take) begin
            n_value = i_left_gt ? i_left_value : i_new_value;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

// ===== tb/block_sort_checker.sv =====
`timescale 1ns / 1ps

module block_sort_checker #(
    parameter int BLOCK_SIZE  = 32,
    parameter int DATA_WIDTH  = 16,
    parameter int TDATA_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input channel as seen on the block's slave side.
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [TDATA_WIDTH-1:0] i_in_data,     // value
    // Output channel as seen on the block's master side.
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [TDATA_WIDTH-1:0] i_out_data,    // sorted_value
    input  logic                   i_out_last,
    output int                     o_fail_count,
    output int                     o_results_pending,
    output int                     o_results_checked
);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         last;
    } t_sorted_result;

    // Values of the block being collected, kept in ascending order.
    logic signed [DATA_WIDTH-1:0] held_values [BLOCK_SIZE];
    int                           held_count = 0;
    t_sorted_result               pending_sorted_q [$];
    int                           fail_count = 0;
    int                           checked_count = 0;

    // Insert one value into the sorted row; a full row releases the whole block.
    task automatic take_value(input logic signed [DATA_WIDTH-1:0] value);
        int             pos;
        t_sorted_result res;
        pos = held_count;
        while (pos > 0 && held_values[pos-1] > value) begin
            held_values[pos] = held_values[pos-1];
            pos--;
        end
        held_values[pos] = value;
        held_count++;
        if (held_count == BLOCK_SIZE) begin
            for (int k = 0; k < BLOCK_SIZE; k++) begin
                res.sorted_value = held_values[k];
                res.last         = (k == BLOCK_SIZE - 1);
                pending_sorted_q.push_back(res);
            end
            held_count = 0;
        end
    endtask

    // Compare one item leaving the block with the oldest expectation.
    task automatic check_result(input logic signed [DATA_WIDTH-1:0] got_value,
                                input logic got_last);
        t_sorted_result exp_res;
        if (pending_sorted_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("Unexpected item: value %0d last %0b with nothing expected",
                         got_value, got_last);
        end else begin
            exp_res = pending_sorted_q.pop_front();
            checked_count++;
            if (exp_res.sorted_value !== got_value || exp_res.last !== got_last) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Mismatch: expected value %0d last %0b, got value %0d last %0b",
                             exp_res.sorted_value, exp_res.last, got_value, got_last);
            end
        end
    endtask

    // Both channels are sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            pending_sorted_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                take_value(i_in_data[DATA_WIDTH-1:0]);
            if (i_out_valid && i_out_ready)
                check_result(i_out_data[DATA_WIDTH-1:0], i_out_last);
        end
        o_fail_count      = fail_count;
        o_results_pending = pending_sorted_q.size();
        o_results_checked = checked_count;
    end

endmodule

// ===== tb/block_ascending_sorter_top_tb.sv =====
`timescale 1ns / 1ps

module block_ascending_sorter_top_tb;

    localparam int BLOCK_SIZE   = 32;
    localparam int DATA_WIDTH   = 16;
    localparam int TDATA_WIDTH  = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } t_idle_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [TDATA_WIDTH-1:0] s_axis_tdata = '0;   // value
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire  [TDATA_WIDTH-1:0] m_axis_tdata;        // sorted_value
    wire                    m_axis_tlast;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;
    int items_sent = 0;
    int quiet_cycles = 0;
    int fail_count;
    int results_pending;
    int results_checked;

    block_ascending_sorter_top #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    block_sort_checker #(
        .BLOCK_SIZE  (BLOCK_SIZE),
        .DATA_WIDTH  (DATA_WIDTH),
        .TDATA_WIDTH (TDATA_WIDTH)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (s_axis_tvalid),
        .i_in_ready        (s_axis_tready),
        .i_in_data         (s_axis_tdata),
        .i_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .i_out_data        (m_axis_tdata),
        .i_out_last        (m_axis_tlast),
        .o_fail_count      (fail_count),
        .o_results_pending (results_pending),
        .o_results_checked (results_checked)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Output side: random stalls, or one long hold-off when asked for.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: ends the run if no item moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 82;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 82;
            end
            default: begin
                send_idle_pct  = 6;
                recv_stall_pct = 6;
            end
        endcase
    endtask

    // Offer one item, after a random gap, and return at the edge that takes it.
    task automatic send_value(input logic [DATA_WIDTH-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_WIDTH'(value);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Hold the input quiet until every result of the full blocks has come back.
    task automatic wait_for_results;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [DATA_WIDTH-1:0] corner_values [20];
        int                    raw;
        corner_values = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                          16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h5555,
                          16'hAAAA, 16'h0100, 16'hFF00, 16'h3039, 16'hCFC7,
                          16'h0001, 16'hFFFF, 16'h7FFE, 16'h8001, 16'h0F0F};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner values and duplicates, topped up with random values.
        set_idling(IDLE_NONE);
        for (int k = 0; k < 20; k++)
            send_value(corner_values[k]);
        for (int k = 20; k < BLOCK_SIZE; k++)
            send_value(DATA_WIDTH'($urandom_range(0, 65535)));
        wait_for_results();

        // Values arriving in descending order, the deepest insertion case.
        set_idling(IDLE_SENDER);
        for (int k = 0; k < BLOCK_SIZE; k++) begin
            raw = 32767 - k * 2000 - int'($urandom_range(0, 999));
            send_value(raw[DATA_WIDTH-1:0]);
        end
        wait_for_results();

        // Narrow range, so most values are repeated.
        set_idling(IDLE_RECEIVER);
        for (int k = 0; k < BLOCK_SIZE; k++) begin
            raw = int'($urandom_range(0, 7)) - 4;
            send_value(raw[DATA_WIDTH-1:0]);
        end
        wait_for_results();

        // Values arriving in ascending order.
        set_idling(IDLE_BOTH);
        for (int k = 0; k < BLOCK_SIZE; k++) begin
            raw = -32768 + k * 2048 + int'($urandom_range(0, 2047));
            send_value(raw[DATA_WIDTH-1:0]);
        end
        wait_for_results();

        // Long output hold: the block fills, stalls and the next items back up.
        // The trailing items form a partial block that must give no result.
        set_idling(IDLE_NONE);
        hold_request = 1'b1;
        for (int k = 0; k < BLOCK_SIZE + 7; k++)
            send_value(DATA_WIDTH'($urandom_range(0, 65535)));
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items: %0d full blocks and a partial one, %0d results checked.",
                 items_sent, items_sent / BLOCK_SIZE, results_checked);
        $display("Blocks held corner values, runs in both orders and heavy duplicates.");
        if (fail_count == 0 && results_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
